// ===== rtl/core/ilir_pkg.sv =====
// Package for the indexed list block: sizes, operation and status codes,
// and the command struct broadcast from the controller to the cell chain.
// No dependencies.
`timescale 1ns / 1ps
package ilir_pkg;

	localparam int CAPACITY = 32;
	localparam int LEN_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int FIELD_IDX_W = 6;
	localparam int FIELD_LEN_W = 6;
	localparam int WORD_W   = 32;
	localparam int CMP_W    = (LEN_W > FIELD_IDX_W) ? LEN_W : FIELD_IDX_W;

	localparam int INIT_LEN_RST = 5;
	localparam int INIT_LEN_CLAMP = (INIT_LEN_RST > CAPACITY) ? CAPACITY : INIT_LEN_RST;

	localparam logic [2:0] OP_FILL   = 3'd0;
	localparam logic [2:0] OP_GET    = 3'd1;
	localparam logic [2:0] OP_SET    = 3'd2;
	localparam logic [2:0] OP_INSERT = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef logic [WORD_W-1:0] word_t;

	// Command seen by every cell; the do_* flags are already qualified
	// by the request being accepted and its index and capacity checks passing.
	typedef struct packed {
		logic             do_fill;
		logic             do_set;
		logic             do_ins;
		logic             do_rem;
		logic [CMP_W-1:0] idx;
		logic [CMP_W-1:0] len;
		word_t            value;
	} cmd_t;

endpackage

// ===== rtl/core/ilir_cell.sv =====
// One list entry of the cell chain: holds a word and takes the command
// value or a neighbor's word. Depends on ilir_pkg.
`timescale 1ns / 1ps
module ilir_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ilir_pkg::cmd_t        cmd,
	input  logic [ilir_pkg::CMP_W-1:0] pos,
	input  ilir_pkg::word_t       left_word,
	input  ilir_pkg::word_t       right_word,
	output ilir_pkg::word_t       word
);
	import ilir_pkg::*;

	word_t            word_q;
	word_t            word_d;
	logic [CMP_W:0]   pos_inc;

	assign pos_inc = {1'b0, pos} + {{CMP_W{1'b0}}, 1'b1};

	always_comb begin
		word_d = word_q;
		if (cmd.do_fill && (pos < cmd.len)) begin
			word_d = cmd.value;
		end else if ((cmd.do_set || cmd.do_ins) && (pos == cmd.idx)) begin
			word_d = cmd.value;
		end else if (cmd.do_ins && (pos > cmd.idx) && (pos <= cmd.len)) begin
			word_d = left_word;
		end else if (cmd.do_rem && (pos >= cmd.idx) && (pos_inc < {1'b0, cmd.len})) begin
			word_d = right_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q <= word_d;
		end
	end

	assign word = word_q;

endmodule

// ===== rtl/core/ilir_ctrl.sv =====
// Controller of the indexed list: holds the live length, checks the
// index of each request and builds the command for the cells. Depends on ilir_pkg.
`timescale 1ns / 1ps
module ilir_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [2:0]                    op,
	input  logic [ilir_pkg::FIELD_IDX_W-1:0] idx,
	input  ilir_pkg::word_t               value,
	input  logic                          cfg_wr_en,
	input  logic [ilir_pkg::FIELD_LEN_W-1:0] cfg_wr_data,
	output ilir_pkg::cmd_t                cmd,
	output logic [1:0]                    status,
	output logic                          get_ok,
	output logic [ilir_pkg::LEN_W-1:0]    len_next,
	output logic [ilir_pkg::LEN_W-1:0]    len_cur
);
	import ilir_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [CMP_W-1:0] len_c;
	logic [CMP_W-1:0] idx_c;
	logic [CMP_W-1:0] cfg_c;
	logic [LEN_W-1:0] cfg_len;
	logic             fill_ok, set_ok, ins_ok, rem_ok;

	assign len_c = CMP_W'(len_q);
	assign idx_c = CMP_W'(idx);
	assign cfg_c = CMP_W'(cfg_wr_data);
	assign cfg_len = (cfg_c > CMP_W'(CAPACITY)) ? LEN_W'(CAPACITY) : LEN_W'(cfg_c);

	always_comb begin
		status  = ST_OK;
		fill_ok = 1'b0;
		set_ok  = 1'b0;
		ins_ok  = 1'b0;
		rem_ok  = 1'b0;
		get_ok  = 1'b0;
		case (op)
			OP_FILL: begin
				fill_ok = 1'b1;
			end
			OP_GET: begin
				if (idx_c < len_c) get_ok = 1'b1;
				else status = ST_RANGE;
			end
			OP_SET: begin
				if (idx_c < len_c) set_ok = 1'b1;
				else status = ST_RANGE;
			end
			OP_INSERT: begin
				if (idx_c > len_c) status = ST_RANGE;
				else if (len_c >= CMP_W'(CAPACITY)) status = ST_FULL;
				else ins_ok = 1'b1;
			end
			OP_REMOVE: begin
				if (idx_c < len_c) rem_ok = 1'b1;
				else status = ST_RANGE;
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
	end

	always_comb begin
		len_next = len_q;
		if (ins_ok) len_next = len_q + LEN_W'(1);
		else if (rem_ok) len_next = len_q - LEN_W'(1);
	end

	assign cmd.do_fill = accept && fill_ok;
	assign cmd.do_set  = accept && set_ok;
	assign cmd.do_ins  = accept && ins_ok;
	assign cmd.do_rem  = accept && rem_ok;
	assign cmd.idx     = idx_c;
	assign cmd.len     = len_c;
	assign cmd.value   = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(INIT_LEN_CLAMP);
		end else if (cfg_wr_en) begin
			len_q <= cfg_len;
		end else if (accept) begin
			len_q <= len_next;
		end
	end

	assign len_cur = len_q;

endmodule

// ===== rtl/core/indexed_list_insert_remove.sv =====
// Top level of the indexed list: controller, chain of entry cells, read
// select and the result register. Depends on ilir_pkg, ilir_ctrl, ilir_cell.
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit words, CAPACITY entries (32 by
// default). Every request (fill, get, set, insert, remove) takes effect on
// acceptance: each entry sits in its own cell, and on insert or remove the
// live cells from the index up take their neighbor's word in the same cycle,
// so the block accepts one request per cycle and returns exactly one result
// per request in the next cycle through a result register; a result still
// waiting for m_tready lets the next request in only as the result is taken.
// The entries clear to zero at reset with no clearing pass; the length
// loads from initial_length (reset 5, saturated to CAPACITY), and a write
// of cfg_wr_data reloads the length at once while the entries keep their
// words. Write the register only while no request is in flight.
module indexed_list_insert_remove (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: initial_length[5:0]
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // index[5:0], value[37:6], zero[39:38]
	input  logic [2:0]  s_tuser,  // operation[2:0]
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // read_value[31:0], status[33:32], length[39:34]
);
	import ilir_pkg::*;

	logic             accept;
	cmd_t             cmd;
	logic [1:0]       status;
	logic             get_ok;
	logic [LEN_W-1:0] len_next;
	logic [LEN_W-1:0] len_cur;
	word_t            words [CAPACITY];
	word_t            rd_word;
	logic             m_valid_q;
	logic [39:0]      m_data_q;

	// Take a new request whenever the result register is empty or drains now.
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ilir_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (s_tuser),
		.idx         (s_tdata[5:0]),
		.value       (s_tdata[37:6]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.get_ok      (get_ok),
		.len_next    (len_next),
		.len_cur     (len_cur)
	);

	// Chain of cells; the ends see a zero neighbor they never take.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (i == 0) begin : g_lo
			assign left_w = '0;
		end else begin : g_lo_n
			assign left_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi
			assign right_w = '0;
		end else begin : g_hi_n
			assign right_w = words[i+1];
		end
		ilir_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.pos        (CMP_W'(i)),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[i])
		);
	end

	// Read the addressed entry before this cycle's update; drive -1 on a bad get.
	always_comb begin
		rd_word = '0;
		if (get_ok) begin
			rd_word = words[cmd.idx[IDX_W-1:0]];
		end else if (s_tuser == OP_GET) begin
			rd_word = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Hold the result payload until it is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {FIELD_LEN_W'(len_next), status, rd_word};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(len_cur) <= CAPACITY)
		else $error("live length above capacity");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.do_rem && !cfg_wr_en) |=> (len_cur == $past(len_cur) - LEN_W'(1)))
		else $error("remove did not shrink the length");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.do_ins && !cfg_wr_en) |=> (len_cur == $past(len_cur) + LEN_W'(1)))
		else $error("insert did not grow the length");

	a_bad_get: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_GET && !get_ok) |=>
		(m_tvalid && m_tdata[31:0] == 32'hFFFF_FFFF && m_tdata[33:32] == ST_RANGE))
		else $error("bad get did not return -1 with range status");
`endif

endmodule

// ===== sim/ilir_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the indexed list block: it mirrors the list and its length,
// predicts one result per accepted request and compares it with the result channel.
// Depends on ilir_pkg.
module ilir_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // index[5:0], value[37:6], zero[39:38]
	input  logic [2:0]  s_tuser,   // operation[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // read_value[31:0], status[33:32], length[39:34]
	output int          fail_count,
	output int          pending,
	output logic [5:0]  live_len
);
	import ilir_pkg::*;

	// Same layout as m_tdata, highest field first.
	typedef struct packed {
		logic [5:0]  length;
		logic [1:0]  status;
		logic [31:0] read_value;
	} list_result_t;

	word_t        list_words [CAPACITY];
	int           list_len;
	list_result_t expected_results [$];

	function automatic int clamp_len(input logic [5:0] n);
		return (int'(n) > CAPACITY) ? CAPACITY : int'(n);
	endfunction

	// Apply one request to the mirrored list and return what the block should answer.
	task automatic apply_request(input logic [2:0] op, input logic [5:0] idx,
			input word_t val, output list_result_t res);
		int k;
		res.read_value = '0;
		res.status = ST_OK;
		case (op)
			OP_FILL: begin
				for (k = 0; k < list_len; k++)
					list_words[k] = val;
			end
			OP_GET: begin
				if (int'(idx) < list_len) begin
					res.read_value = list_words[idx[IDX_W-1:0]];
				end else begin
					res.read_value = '1;
					res.status = ST_RANGE;
				end
			end
			OP_SET: begin
				if (int'(idx) < list_len)
					list_words[idx[IDX_W-1:0]] = val;
				else
					res.status = ST_RANGE;
			end
			OP_INSERT: begin
				if (int'(idx) > list_len) begin
					res.status = ST_RANGE;
				end else if (list_len >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (k = list_len; k > int'(idx); k--)
						list_words[k] = list_words[k - 1];
					list_words[idx[IDX_W-1:0]] = val;
					list_len++;
				end
			end
			OP_REMOVE: begin
				// the vacated top entry keeps its old word
				if (int'(idx) < list_len) begin
					for (k = int'(idx); k + 1 < list_len; k++)
						list_words[k] = list_words[k + 1];
					list_len--;
				end else begin
					res.status = ST_RANGE;
				end
			end
			default: begin
				res.status = ST_RANGE;
			end
		endcase
		res.length = list_len[5:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : list_watch
		list_result_t want;
		list_result_t got;
		int           misses;
		int           k;
		if (!arst_n) begin
			for (k = 0; k < CAPACITY; k++)
				list_words[k] = '0;
			list_len = clamp_len(6'(INIT_LEN_RST));
			expected_results.delete();
			fail_count <= 0;
		end else begin
			misses = 0;
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					misses++;
				end else begin
					want = expected_results.pop_front();
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							$signed(want.read_value), $signed(got.read_value));
						misses++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						misses++;
					end
					if (got.length !== want.length) begin
						$error("length: expected %0d, got %0d", want.length, got.length);
						misses++;
					end
				end
			end
			if (cfg_wr_en)
				list_len = clamp_len(cfg_wr_data);
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata[5:0], s_tdata[37:6], want);
				expected_results.push_back(want);
			end
			fail_count <= fail_count + misses;
		end
		pending <= expected_results.size();
		live_len <= list_len[5:0];
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the indexed list testbench: clock, reset, request stimulus, result-side
// stalls, length register phases and the verdict. Depends on ilir_pkg, ilir_checker
// and the indexed_list_insert_remove RTL.
module tb_top;
	import ilir_pkg::*;

	// Codes 5 to 7 are not operations; the block must answer them with a range status.
	localparam logic [2:0] OP_UNUSED_LO = OP_REMOVE + 3'd1;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	localparam word_t WORD_MAX  = 32'h7FFF_FFFF;
	localparam word_t WORD_MIN  = 32'h8000_0000;
	localparam word_t WORD_ONES = 32'hFFFF_FFFF;

	localparam int QUIET_LIMIT = 1000;  // cycles with no handshake before giving up
	localparam int LONG_HOLD   = 64;    // result-side hold-off that backs up the block

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [5:0]  cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	int          fail_count;
	int          pending;
	logic [5:0]  live_len;
	logic        rx_holding = 1'b0;
	int          burst_left = 0;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	indexed_list_insert_remove u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	ilir_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.live_len    (live_len)
	);

	// Offer one request and hold it until the block takes it. Requests go out in
	// bursts; between bursts drop tvalid for a random gap, except while the result
	// side is holding off, so that the block fills up and stalls its input.
	task automatic send_request(input logic [2:0] op, input logic [5:0] idx, input word_t val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0 && !rx_holding) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, val, idx};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop offering and wait until every request has its result, then let the
	// result register settle. Wait for an edge first so the pending count includes
	// the request taken at the current edge.
	task automatic drain_results;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Reload the length only while nothing is in flight; the entries keep their words.
	task automatic write_initial_length(input logic [5:0] n);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Random requests. Most indexes land between 0 and the current length, where
	// the list actually moves; the rest cover the whole index field. grow_pct tips
	// the insert/remove balance so phases can drive the list to full or to empty.
	task automatic random_requests(input int count, input int grow_pct);
		int          n;
		int          pick;
		logic [2:0]  op;
		logic [5:0]  idx;
		word_t       val;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				op = OP_FILL;
			else if (pick < 8)
				op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			else if (pick < 24)
				op = OP_GET;
			else if (pick < 38)
				op = OP_SET;
			else if (pick < 38 + (62 * grow_pct) / 100)
				op = OP_INSERT;
			else
				op = OP_REMOVE;
			if ($urandom_range(0, 4) == 0)
				idx = 6'($urandom_range(0, 63));
			else
				idx = 6'($urandom_range(0, live_len));
			case ($urandom_range(0, 11))
				0:       val = WORD_MAX;
				1:       val = WORD_MIN;
				2:       val = WORD_ONES;
				3:       val = '0;
				default: val = $urandom();
			endcase
			send_request(op, idx, val);
		end
	endtask

	// Result side: stall on a pattern of its own, in segments of random length.
	// Once early on, and now and then later, hold tready low for a long stretch.
	initial begin : result_stalls
		int seg;
		int mode;
		int elapsed;
		bit held_once;
		elapsed = 0;
		held_once = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ((!held_once && elapsed > 300) || $urandom_range(0, 150) == 0) begin
				rx_holding <= 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rx_holding <= 1'b0;
				elapsed += LONG_HOLD;
				held_once = 1;
			end else begin
				seg = $urandom_range(1, 40);
				mode = $urandom_range(0, 3);
				repeat (seg) begin
					case (mode)
						0:       m_tready <= 1'b1;
						1:       m_tready <= 1'($urandom_range(0, 1));
						2:       m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= ~m_tready;
					endcase
					@(posedge clk);
					elapsed++;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length 5 after reset, all entries zero.
		send_request(OP_GET, 6'd0, '0);
		send_request(OP_GET, 6'd5, WORD_ONES);         // one past the end
		send_request(OP_GET, 6'd63, WORD_ONES);        // top of the index field
		send_request(OP_FILL, 6'd63, 32'h1234_5678);   // index ignored
		send_request(OP_SET, 6'd0, WORD_MAX);
		send_request(OP_SET, 6'd4, WORD_MIN);
		send_request(OP_SET, 6'd5, WORD_ONES);         // out of range, no change
		send_request(OP_INSERT, 6'd0, WORD_ONES);      // at the head
		send_request(OP_INSERT, 6'd6, 32'h0000_0001);  // append at the length
		send_request(OP_INSERT, 6'd8, 32'h0000_0002);  // past the length
		send_request(OP_REMOVE, 6'd0, '0);
		send_request(OP_REMOVE, 6'd5, '0);             // last entry
		send_request(OP_REMOVE, 6'd63, '0);
		send_request(OP_UNUSED_LO, 6'd0, WORD_MAX);
		send_request(OP_UNUSED_LO + 3'd1, 6'd1, WORD_MIN);
		send_request(OP_UNUSED_HI, 6'd63, WORD_ONES);
		send_request(OP_GET, 6'd4, '0);

		// Full list: inserts are refused while it is full unless the index is already bad.
		write_initial_length(6'd32);
		send_request(OP_GET, 6'd31, '0);
		send_request(OP_INSERT, 6'd0, WORD_MAX);
		send_request(OP_INSERT, 6'd33, WORD_MAX);
		send_request(OP_REMOVE, 6'd31, '0);
		send_request(OP_INSERT, 6'd31, WORD_MIN);
		random_requests(150, 50);

		// Empty list: nothing to read or remove, fill does nothing.
		write_initial_length(6'd0);
		send_request(OP_GET, 6'd0, '0);
		send_request(OP_REMOVE, 6'd0, '0);
		send_request(OP_FILL, 6'd0, WORD_ONES);
		send_request(OP_INSERT, 6'd1, WORD_ONES);
		send_request(OP_INSERT, 6'd0, 32'hCAFE_0001);
		random_requests(200, 75);

		// A length above capacity saturates; then shrink toward empty.
		write_initial_length(6'd63);
		random_requests(150, 25);

		write_initial_length(6'($urandom_range(1, 31)));
		random_requests(200, 50);

		write_initial_length(6'(INIT_LEN_RST));
		random_requests(150, 50);

		drain_results();
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ilir_pkg.sv
rtl/core/ilir_cell.sv
rtl/core/ilir_ctrl.sv
rtl/core/indexed_list_insert_remove.sv
sim/ilir_checker.sv
sim/tb_top.sv
